### design/bmlsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmlsu_pkg
// Shared types for the byte memory load/store unit: access codes,
// controller command and datapath status.
// ----------------------------------------------------------------------------
package bmlsu_pkg;

    typedef enum logic [2:0] {
        ACT_LDR   = 3'd0,
        ACT_LDRB  = 3'd1,
        ACT_LDRH  = 3'd2,
        ACT_LDRSB = 3'd3,
        ACT_LDRSH = 3'd4,
        ACT_STR   = 3'd5,
        ACT_STRB  = 3'd6,
        ACT_STRH  = 3'd7
    } t_action;

    localparam int LANES = 4;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // take the input word
        logic mem_go;    // address checked this cycle; issue bank accesses
        logic take_read; // bank read data valid; build the load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fault;
        logic is_load;
    } t_status;

    // bytes touched by an access
    function automatic logic [2:0] access_size(input t_action act);
        logic [2:0] sz;
        begin
            unique case (act) inside
                ACT_LDR, ACT_STR:              sz = 3'd4;
                ACT_LDRH, ACT_LDRSH, ACT_STRH: sz = 3'd2;
                default:                       sz = 3'd1;
            endcase
            return sz;
        end
    endfunction

endpackage

### design/bmlsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmlsu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bmlsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/bmlsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmlsu_ctrl
// Sequencer: accept a word, check the address, access the banks, hold the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module bmlsu_ctrl
    import bmlsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && r_in_ready) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_ADDR;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_ADDR: begin
                    if (i_status.is_load && !i_status.fault) begin
                        r_state <= S_READ;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.capture   = (r_state == S_IDLE) && i_valid && r_in_ready;
        o_cmd.mem_go    = (r_state == S_ADDR);
        o_cmd.take_read = (r_state == S_READ);
    end

    assign o_ready = r_in_ready;
    assign o_valid = r_out_valid;

endmodule

### design/bmlsu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmlsu_dpath
// Address add, bounds check, four byte-wide banks and load alignment.
// ----------------------------------------------------------------------------
module bmlsu_dpath
    import bmlsu_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_offset_value,
    input  logic [31:0] i_store_data,
    output logic [31:0] o_load_data,
    output logic        o_fault
);

    localparam int BANK_DEPTH = (MEM_BYTES + LANES - 1) / LANES;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    t_action     r_action;
    logic [31:0] r_addr;
    logic [31:0] r_sdata;
    logic [31:0] r_load_data;
    logic        r_fault;

    logic [2:0]  size;
    logic [1:0]  lane;
    logic [AW-1:0] row_base;
    logic        fault;
    logic        is_load;
    logic [31:0] wrot;
    logic [31:0] rd;
    logic [31:0] rrot;
    logic [31:0] ld_val;

    // input and address registers; the add is kept apart from the bounds compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_addr   <= i_base_value + i_offset_value;
            r_sdata  <= i_store_data;
        end
    end

    assign size     = access_size(r_action);
    assign lane     = r_addr[1:0];
    assign row_base = r_addr[AW+1:2];
    assign fault    = ({2'b00, r_addr} + 34'(size)) > 34'(MEM_BYTES);
    assign is_load  = (r_action == ACT_LDR) || (r_action == ACT_LDRB) ||
                      (r_action == ACT_LDRH) || (r_action == ACT_LDRSB) ||
                      (r_action == ACT_LDRSH);

    assign o_status.fault   = fault;
    assign o_status.is_load = is_load;

    // store data rotated so byte k lands in bank (addr + k) mod 4
    always_comb begin
        case (lane)
            2'd0:    wrot = r_sdata;
            2'd1:    wrot = {r_sdata[23:0], r_sdata[31:24]};
            2'd2:    wrot = {r_sdata[15:0], r_sdata[31:16]};
            default: wrot = {r_sdata[7:0],  r_sdata[31:8]};
        endcase
    end

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic [1:0]    k;
        logic          en;
        logic [AW-1:0] row;

        assign k   = 2'(b) - lane;
        assign en  = i_cmd.mem_go && !fault && ({1'b0, k} < size);
        // banks below the start lane hold bytes of the next row
        assign row = row_base + AW'(2'(b) < lane);

        bmlsu_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (!is_load),
            .i_addr  (row),
            .i_wdata (wrot[8*b +: 8]),
            .o_rdata (rd[8*b +: 8])
        );
    end

    // undo the lane rotation: byte 0 of the result comes from the start lane
    always_comb begin
        case (lane)
            2'd0:    rrot = rd;
            2'd1:    rrot = {rd[7:0],  rd[31:8]};
            2'd2:    rrot = {rd[15:0], rd[31:16]};
            default: rrot = {rd[23:0], rd[31:24]};
        endcase
    end

    always_comb begin
        case (r_action)
            ACT_LDR:   ld_val = rrot;
            ACT_LDRB:  ld_val = {24'd0, rrot[7:0]};
            ACT_LDRH:  ld_val = {16'd0, rrot[15:0]};
            ACT_LDRSB: ld_val = {{24{rrot[7]}}, rrot[7:0]};
            ACT_LDRSH: ld_val = {{16{rrot[15]}}, rrot[15:0]};
            default:   ld_val = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= 1'b0;
        end else if (i_cmd.mem_go) begin
            r_fault <= fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_go) begin
            r_load_data <= 32'd0;
        end else if (i_cmd.take_read) begin
            r_load_data <= ld_val;
        end
    end

    assign o_load_data = r_load_data;
    assign o_fault     = r_fault;

endmodule

### design/byte_memory_load_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_memory_load_store_unit
// Memory stage: little-endian byte-addressed load/store, unaligned allowed.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one access word: action, base,
// offset and store data. Address = base + offset mod 2^32. Output channel
// (o_valid / i_ready) returns one result word per access: load data (zero
// for stores and faults) and a fault flag for accesses past MEM_BYTES.
// Memory is four byte-wide banks of MEM_BYTES/4 rows, one port each; every
// byte of an access sits in a different bank, so any access is served by a
// single access to each bank that it touches.
// Sequence: stores and faults pass through S_ADDR to S_OUT; loads also pass
// through S_READ, the extra state for the registered bank read.
// One word is in flight at a time: the input stays closed from acceptance
// until the result is taken, and a stalled result holds and blocks the
// input until taken.
// Reset clears the sequencer and the fault flag; memory contents are undefined
// until written, and o_ready rises in the cycle after reset is released.
// ----------------------------------------------------------------------------
module byte_memory_load_store_unit
    import bmlsu_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_offset_value,
    input  logic [31:0] i_store_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_load_data,
    output logic        o_fault
);

    t_cmd    cmd;
    t_status status;

    bmlsu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bmlsu_dpath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_base_value   (i_base_value),
        .i_offset_value (i_offset_value),
        .i_store_data   (i_store_data),
        .o_load_data    (o_load_data),
        .o_fault        (o_fault)
    );

endmodule

### design/bmlsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmlsu_checker
// Port-level checks for the load/store unit, bound to the top level.
// ----------------------------------------------------------------------------
module bmlsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_load_data,
    input logic        o_fault
);

    // a faulted access returns no data
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_load_data == 32'd0))
        else $error("fault result with nonzero load data");

    // one word in flight: never ready for input while a result is shown
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while result pending");

    // accepting a word closes the input until its result is delivered
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (!o_ready && !o_valid))
        else $error("input still open after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_load_data) && $stable(o_fault)))
        else $error("result changed while stalled");

endmodule

bind byte_memory_load_store_unit bmlsu_checker u_chk (.*);
